/* rtl/spq_pkg.sv */
// Package with the shared constants and types of the sorted priority queue.
package spq_pkg;

    // Number of cells in the queue.
    localparam int DEPTH = 16;
    // Width of the entry count, which must hold DEPTH itself.
    localparam int CNT_W = $clog2(DEPTH + 1);
    // Fixed widths of the beat fields and configuration registers.
    localparam int VAL_W = 32;
    localparam int OCC_W = 5;
    localparam int CAP_W = 5;
    localparam int CFG_W = 5;

    // Configuration register indexes.
    localparam logic CFG_ORDER_MODE = 1'b0;
    localparam logic CFG_CAPACITY   = 1'b1;

    // Input actions.
    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Control broadcast to every cell.
    typedef struct packed {
        logic ins;   // insert the new value this cycle
        logic rem;   // remove the head this cycle
        logic desc;  // descending order: larger values go first
    } t_cell_ctl;

endpackage

/* rtl/spq_in_if.sv */
// Input channel: action and value under a valid/ready handshake.
interface spq_in_if
    import spq_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    action;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

/* rtl/spq_out_if.sv */
// Result channel: status, removed value and occupancy under a valid/ready handshake.
interface spq_out_if
    import spq_pkg::*;
();
    logic                    valid;
    logic                    ready;
    t_status                 status;
    logic signed [VAL_W-1:0] removed_value;
    logic [OCC_W-1:0]        occupancy;

    modport source (output valid, output status, output removed_value, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input occupancy,
                    output ready);
endinterface

/* rtl/spq_cell.sv */
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
module spq_cell
    import spq_pkg::*;
(
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_occ,
    input  logic                    i_tail,
    input  logic                    i_hit,
    output logic                    o_hit,
    input  logic signed [VAL_W-1:0] i_left,
    input  logic signed [VAL_W-1:0] i_right,
    output logic signed [VAL_W-1:0] o_val
);

    logic signed [VAL_W-1:0] r_val;
    logic                    w_before;
    logic                    w_take_new;
    logic                    w_shift;

    // Does the new value strictly precede this entry under the current order?
    assign w_before = i_ctl.desc ? (i_value > r_val) : (i_value < r_val);

    // The first held entry that the new value precedes marks the insert place.
    assign o_hit = i_hit | (i_occ & w_before);

    // Take the new value at the insert place, or at the tail when nothing matched.
    assign w_take_new = !i_hit && ((i_occ && w_before) || i_tail);
    // Behind the insert place, every held entry and the tail move back one cell.
    assign w_shift    = i_hit && (i_occ || i_tail);

    // Entry register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (w_take_new) begin
                r_val <= i_value;
            end else if (w_shift) begin
                r_val <= i_left;
            end
        end else if (i_ctl.rem) begin
            r_val <= i_right;
        end
    end

    assign o_val = r_val;

endmodule

/* rtl/sorted_priority_queue.sv */
// Top level of the sorted priority queue: a chain of entry cells with count and result register.
//
//   channel   direction  beat fields                               accepted when
//   i_in      in         action, value                             valid && ready
//   o_res     out        status, removed_value, occupancy          valid && ready
//   i_cfg_*   in         index (0 order_mode, 1 capacity_limit)    i_cfg_we high
//
// A new item is accepted in every cycle unless a result is stalled. The clock period is set by
// the match signal that ripples from the head cell to the tail cell to find the insert place.
// A synchronous active-low reset empties the queue and restores ascending order and full
// capacity; the entry cells themselves are not cleared.
// While a result waits on a stalled output, no new item is accepted.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    spq_in_if.sink           i_in,
    spq_out_if.source        o_res,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic                    r_desc;
    logic [CAP_W-1:0]        r_cap;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_ovalid;
    t_status                 r_status;
    t_status                 n_status;
    logic signed [VAL_W-1:0] r_removed;
    logic signed [VAL_W-1:0] n_removed;
    logic [OCC_W-1:0]        r_occ;

    logic                    w_accept;
    logic                    w_full;
    logic                    w_empty;
    t_cell_ctl               w_ctl;

    logic signed [VAL_W-1:0] w_val [DEPTH];
    logic [DEPTH:0]          w_hit;

    // Input side is free when no result waits or the waiting one leaves now.
    assign i_in.ready = !r_ovalid || o_res.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // Full when the count reaches the limit or the physical depth.
    assign w_full  = ({{CNT_W{1'b0}}, r_cap} <= {{CAP_W{1'b0}}, r_count})
                     || (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    // Cell control for this cycle.
    always_comb begin
        w_ctl.ins  = w_accept && (i_in.action == ACT_ENQUEUE) && !w_full;
        w_ctl.rem  = w_accept && (i_in.action == ACT_DEQUEUE) && !w_empty;
        w_ctl.desc = r_desc;
    end

    // Chain of cells, head at index 0.
    assign w_hit[0] = 1'b0;
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [VAL_W-1:0] w_left;
        logic signed [VAL_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = i_in.value;
        end else begin : g_body
            assign w_left = w_val[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_val[g];
        end else begin : g_mid
            assign w_right = w_val[g+1];
        end

        spq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_value (i_in.value),
            .i_occ   (CNT_W'(g) < r_count),
            .i_tail  (CNT_W'(g) == r_count),
            .i_hit   (w_hit[g]),
            .o_hit   (w_hit[g+1]),
            .i_left  (w_left),
            .i_right (w_right),
            .o_val   (w_val[g])
        );
    end

    // Next count and result fields.
    always_comb begin
        n_count   = r_count;
        n_status  = ST_DONE;
        n_removed = '0;
        if (i_in.action == ACT_ENQUEUE) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count   = r_count - CNT_W'(1);
                n_removed = w_val[0];
            end
        end
    end

    // Configuration registers, count and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc   <= 1'b0;
            r_cap    <= CAP_W'(16);
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ORDER_MODE: r_desc <= i_cfg_data[0];
                    CFG_CAPACITY:   r_cap  <= i_cfg_data[CAP_W-1:0];
                    default:        r_desc <= r_desc;
                endcase
            end
            if (w_accept) begin
                r_count  <= n_count;
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
            r_occ     <= OCC_W'(n_count);
        end
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.status        = r_status;
    assign o_res.removed_value = r_removed;
    assign o_res.occupancy     = r_occ;

endmodule
